>>> src/base64_stream_passthrough_decoder_top_defines.svh
// Assertion macros shared by the base64 decoder RTL.
`ifndef BASE64_STREAM_PASSTHROUGH_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_PASSTHROUGH_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property holds in the same cycle.
`define B64D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define B64D_ASSERT(lbl, prop, msg)
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/b64d_pkg.sv
// Shared types, codes and alphabet lookup for the base64 decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned AccW   = 18;
	localparam int unsigned MaxRes = 3;

	localparam logic [7:0] SYM_BAD   = 8'd255;
	localparam logic [7:0] SYM_PAD   = 8'd254;
	localparam logic [7:0] SYM_PLUS  = 8'd62;
	localparam logic [7:0] SYM_SLASH = 8'd63;

	// Results of one input word, first result in bytes[0].
	typedef struct packed {
		logic [MaxRes-1:0][ByteW-1:0] bytes;
		logic                         raw;
		logic [1:0]                   cnt;
	} b64d_res_t;

	// Map a character to its sextet value, or to the pad / non-alphabet codes.
	function automatic logic [7:0] sym_value(input logic [7:0] c);
		logic [7:0] v;
		begin
			if (c inside {["A":"Z"]}) begin
				v = c - 8'h41;
			end else if (c inside {["a":"z"]}) begin
				v = c - 8'h61 + 8'd26;
			end else if (c inside {["0":"9"]}) begin
				v = c - 8'h30 + 8'd52;
			end else if (c == 8'h2B) begin
				v = SYM_PLUS;
			end else if (c == 8'h2F) begin
				v = SYM_SLASH;
			end else if (c == 8'h3D) begin
				v = SYM_PAD;
			end else begin
				v = SYM_BAD;
			end
			return v;
		end
	endfunction

endpackage

>>> src/b64d_decode.sv
// Decode of one character against the open group: results and next group state.
`timescale 1ns / 1ps

module b64d_decode
	import b64d_pkg::*;
(
	input  logic [7:0]      in_char,
	input  logic            end_of_text,
	input  logic [1:0]      grp_cnt,
	input  logic [AccW-1:0] acc,
	output b64d_res_t       res,
	output logic [1:0]      nxt_cnt,
	output logic [AccW-1:0] nxt_acc
);

	// Close a partial group with zero sextets.
	function automatic b64d_res_t close_group(input logic [1:0] cnt, input logic [AccW-1:0] a);
		b64d_res_t r;
		begin
			r = '0;
			case (cnt)
				2'd1: begin
					r.bytes[0] = {a[5:0], 2'b00};
					r.cnt      = 2'd1;
				end
				2'd2: begin
					r.bytes[0] = a[11:4];
					r.cnt      = 2'd1;
				end
				2'd3: begin
					r.bytes[0] = a[17:10];
					r.bytes[1] = a[9:2];
					r.cnt      = 2'd2;
				end
				default: begin
					r.cnt = 2'd0;
				end
			endcase
			return r;
		end
	endfunction

	logic [7:0]      sym;
	logic [1:0]      sh_cnt;
	logic [AccW-1:0] sh_acc;

	always_comb begin
		sym     = sym_value(in_char);
		sh_cnt  = grp_cnt + 2'd1;
		sh_acc  = {acc[AccW-7:0], sym[5:0]};
		res     = '0;
		nxt_cnt = grp_cnt;
		nxt_acc = acc;
		if (sym == SYM_BAD) begin
			// pass the character through and drop the open group
			res.bytes[0] = in_char;
			res.raw      = 1'b1;
			res.cnt      = 2'd1;
			nxt_cnt      = 2'd0;
			nxt_acc      = '0;
		end else if (sym == SYM_PAD) begin
			res     = close_group(grp_cnt, acc);
			nxt_cnt = 2'd0;
			nxt_acc = '0;
		end else if (grp_cnt == 2'd3) begin
			res.bytes[0] = acc[17:10];
			res.bytes[1] = acc[9:2];
			res.bytes[2] = {acc[1:0], sym[5:0]};
			res.cnt      = 2'd3;
			nxt_cnt      = 2'd0;
			nxt_acc      = '0;
		end else if (end_of_text) begin
			// flush the group this sextet leaves open
			res     = close_group(sh_cnt, sh_acc);
			nxt_cnt = 2'd0;
			nxt_acc = '0;
		end else begin
			nxt_cnt = sh_cnt;
			nxt_acc = sh_acc;
		end
	end

endmodule

>>> src/base64_stream_passthrough_decoder_top.sv
// Top level of the streaming base64 decoder with raw passthrough.
`timescale 1ns / 1ps
`include "base64_stream_passthrough_decoder_top_defines.svh"

// Takes one encoded character per word and returns decoded bytes, one per output
// word: a character yields zero to three results, the last flagged by last_of_run,
// and a non-alphabet character comes back unchanged with is_raw set. A word passes
// an input register and is decoded in one step into a three-byte result buffer,
// from which the first result is offered. The input side takes a word every cycle
// as long as the result buffer drains; the output port moves one byte per cycle
// while out_stall is low. A two-word input register pair keeps in_stall a
// registered signal.
module base64_stream_passthrough_decoder_top
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_raw,
	output logic       last_of_run
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            eot_s1;
	logic            skid_valid_q;
	logic [7:0]      skid_char_q;
	logic            skid_eot_q;

	logic [1:0]      grp_cnt_q;
	logic [AccW-1:0] acc_q;

	logic [MaxRes-1:0][ByteW-1:0] res_bytes_q;
	logic                         res_raw_q;
	logic [1:0]                   res_cnt_q;

	b64d_res_t       dec;
	logic [1:0]      nxt_cnt;
	logic [AccW-1:0] nxt_acc;

	logic in_acc;
	logic out_acc;
	logic buf_free;
	logic take;

	assign in_stall    = skid_valid_q;
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = (res_cnt_q != 2'd0);
	assign out_acc     = out_valid && !out_stall;
	assign out_byte    = res_bytes_q[0];
	assign is_raw      = res_raw_q;
	assign last_of_run = (res_cnt_q == 2'd1);
	// buffer can load when empty or its last result leaves this cycle
	assign buf_free    = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && out_acc);
	assign take        = valid_s1 && buf_free;

	b64d_decode u_decode (
		.in_char     (char_s1),
		.end_of_text (eot_s1),
		.grp_cnt     (grp_cnt_q),
		.acc         (acc_q),
		.res         (dec),
		.nxt_cnt     (nxt_cnt),
		.nxt_acc     (nxt_acc)
	);

	// input register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					valid_s1     <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					valid_s1 <= in_acc;
				end
			end else if (in_acc) begin
				if (!valid_s1) begin
					valid_s1 <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			char_s1 <= skid_char_q;
			eot_s1  <= skid_eot_q;
		end else if (in_acc && (take || !valid_s1)) begin
			char_s1 <= in_char;
			eot_s1  <= end_of_text;
		end
		if (in_acc && valid_s1 && !take) begin
			skid_char_q <= in_char;
			skid_eot_q  <= end_of_text;
		end
	end

	// group state and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= 2'd0;
			acc_q     <= '0;
			res_cnt_q <= 2'd0;
		end else begin
			if (take) begin
				grp_cnt_q <= nxt_cnt;
				acc_q     <= nxt_acc;
				res_cnt_q <= dec.cnt;
			end else if (out_acc) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	// result buffer: load on take, otherwise advance on each delivered word
	always_ff @(posedge clk) begin
		if (take) begin
			res_bytes_q <= dec.bytes;
			res_raw_q   <= dec.raw;
		end else if (out_acc) begin
			res_bytes_q[0] <= res_bytes_q[1];
			res_bytes_q[1] <= res_bytes_q[2];
		end
	end

	`B64D_ASSERT(a_skid_behind_head, !skid_valid_q || valid_s1, "skid full while head empty")
	`B64D_ASSERT(a_raw_alone, !(out_valid && is_raw) || last_of_run, "raw byte not alone")
	`B64D_ASSERT(a_empty_group_clear, (grp_cnt_q != 2'd0) || (acc_q == '0), "stale sextets")
	`B64D_ASSERT_NEXT(a_eot_flush, take && eot_s1, grp_cnt_q == 2'd0, "group open after end")

endmodule
